// File: rtl/core/rbr_pkg.sv
// Shared types and constants for the response button radio responder.
package rbr_pkg;

  // Item kinds on the input channel
  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_BUTTON = 2'd1;
  localparam logic [1:0] REQ_RX     = 2'd2;
  localparam logic [1:0] REQ_SUPPLY = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_OWN_ADDRESS  = 3'd0;
  localparam logic [2:0] REG_RESET_CODE   = 3'd1;
  localparam logic [2:0] REG_LED_COMMAND  = 3'd2;
  localparam logic [2:0] REG_LED_ON       = 3'd3;
  localparam logic [2:0] REG_LED_OFF      = 3'd4;
  localparam logic [2:0] REG_LED_BLINK    = 3'd5;
  localparam logic [2:0] REG_NOT_PUSHED   = 3'd6;
  localparam logic [2:0] REG_BLINK_PERIOD = 3'd7;

  // CRC-16 generator polynomial
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Commands into the CRC engine
  typedef struct packed {
    logic       start;
    logic       clear;
    logic [7:0] data;
  } crc_cmd_t;

  // Status out of the CRC engine
  typedef struct packed {
    logic        busy;
    logic [15:0] crc;
  } crc_stat_t;

endpackage

// File: rtl/core/rbr_crc_engine.sv
// Bit-serial CRC-16 engine shared by packet check and reply generation.
module rbr_crc_engine
  import rbr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  crc_cmd_t  cmd,
  output crc_stat_t stat
);

  logic [15:0] crc_r, crc_nxt;
  logic [3:0]  cnt_r, cnt_nxt;

  // One shift step of the MSB-first CRC
  function automatic logic [15:0] crc_step(input logic [15:0] c);
    crc_step = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
  endfunction

  // Clear, load a byte into the top, or shift one bit per cycle
  always_comb begin
    crc_nxt = crc_r;
    cnt_nxt = cnt_r;
    priority if (cmd.clear) begin
      crc_nxt = '0;
      cnt_nxt = '0;
    end else if (cmd.start) begin
      crc_nxt = crc_r ^ {cmd.data, 8'h00};
      cnt_nxt = 4'd8;
    end else if (cnt_r != 4'd0) begin
      crc_nxt = crc_step(crc_r);
      cnt_nxt = cnt_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= '0;
      cnt_r <= '0;
    end else begin
      crc_r <= crc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign stat.busy = (cnt_r != 4'd0);
  assign stat.crc  = crc_r;

endmodule

// File: rtl/core/response_button_radio_responder.sv
// Top level: game button responder with tick, button, radio and supply items.
//
// Usage: one input channel (in_valid/in_stall) carries four kinds of item:
// a millisecond tick, a button edge, a received payload byte and a new
// supply word. One result channel (out_valid/out_stall) returns results.
// Tick, button and supply items give one status result in the cycle after
// acceptance. A payload byte's result waits while a byte shifts through
// the CRC (all but the last two bytes of a packet). A good packet for this
// address gives a reply of PAYLOAD_BYTES bytes; each of the first
// PAYLOAD_BYTES-2 bytes is shifted through the bit-serial CRC
// engine (one bit per cycle) that is shared by packet check and reply.
// The block works on one item at a time: a new item is taken once the
// previous item's results are all issued and the output register is empty.
// A stall on the result side holds the output register and the sequencer.
// Reset (rst_n low, synchronous) clears counters, flags, LED, receive state
// and loads the register defaults; no clearing pass is needed. The user must
// keep configuration writes (cfg_we/cfg_index/cfg_data) to idle, unenforced.
module response_button_radio_responder
  import rbr_pkg::*;
#(
  parameter int PAYLOAD_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic        in_pin_low,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_rx_last,
  input  logic [31:0] in_supply_word,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_tx_valid,
  output logic [7:0]  out_tx_byte,
  output logic        out_tx_last,
  output logic        out_led_lit
);

  localparam int POS_W = $clog2(PAYLOAD_BYTES + 1);
  localparam int IDX_W = $clog2(PAYLOAD_BYTES);
  localparam logic [POS_W-1:0] POS_FULL    = POS_W'(PAYLOAD_BYTES);
  localparam logic [POS_W-1:0] POS_TRL_HI  = POS_W'(PAYLOAD_BYTES - 2);
  localparam logic [POS_W-1:0] POS_TRL_LO  = POS_W'(PAYLOAD_BYTES - 1);
  localparam logic [POS_W-1:0] POS_HEAD    = POS_W'(3);
  localparam logic [IDX_W-1:0] IDX_CRC_HI  = IDX_W'(PAYLOAD_BYTES - 2);
  localparam logic [IDX_W-1:0] IDX_CRC_LO  = IDX_W'(PAYLOAD_BYTES - 1);

  // Sequencer states
  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_RX_WAIT = 2'd1;
  localparam logic [1:0] ST_TX_LOAD = 2'd2;
  localparam logic [1:0] ST_TX_WAIT = 2'd3;

  // Configuration registers
  logic [7:0]  own_address_r, reset_code_r, led_command_r;
  logic [7:0]  led_on_r, led_off_r, led_blink_r, blink_period_r;
  logic [31:0] not_pushed_r;

  // Block state
  logic [1:0]       state_r, state_nxt;
  logic [31:0]      ms_count_r, ms_count_nxt;
  logic [31:0]      press_time_r, press_time_nxt;
  logic             pressed_r, pressed_nxt;
  logic             blink_mode_r, blink_mode_nxt;
  logic [7:0]       blink_count_r, blink_count_nxt;
  logic             led_r, led_nxt;
  logic [31:0]      supply_r, supply_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       head_r [3], head_nxt [3];
  logic [15:0]      trailer_r, trailer_nxt;
  logic             last_r, last_nxt;
  logic             whole_r, whole_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  // Output register
  logic       out_valid_r, out_valid_nxt;
  logic       out_tx_valid_r, out_tx_valid_nxt;
  logic [7:0] out_tx_byte_r, out_tx_byte_nxt;
  logic       out_tx_last_r, out_tx_last_nxt;
  logic       out_led_r, out_led_nxt;

  crc_cmd_t  crc_cmd;
  crc_stat_t crc_stat;

  logic        in_take;
  logic        out_free;
  logic [7:0]  blink_inc;
  logic        good;
  logic [31:0] time_word;
  logic [7:0]  reply_byte;

  rbr_crc_engine u_crc (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (crc_cmd),
    .stat  (crc_stat)
  );

  assign in_stall = (state_r != ST_IDLE) || out_valid_r;
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign blink_inc = blink_count_r + 8'd1;
  assign good      = whole_r && (crc_stat.crc == trailer_r);
  assign time_word = pressed_r ? press_time_r : not_pushed_r;

  // Reply byte for the current index
  always_comb begin
    unique case (idx_r)
      IDX_W'(0):  reply_byte = own_address_r;
      IDX_W'(1):  reply_byte = time_word[7:0];
      IDX_W'(2):  reply_byte = time_word[15:8];
      IDX_W'(3):  reply_byte = time_word[23:16];
      IDX_W'(4):  reply_byte = time_word[31:24];
      IDX_W'(5):  reply_byte = supply_r[7:0];
      IDX_W'(6):  reply_byte = supply_r[15:8];
      IDX_W'(7):  reply_byte = supply_r[23:16];
      IDX_W'(8):  reply_byte = supply_r[31:24];
      IDX_CRC_HI: reply_byte = crc_stat.crc[15:8];
      IDX_CRC_LO: reply_byte = crc_stat.crc[7:0];
      default:    reply_byte = 8'h00;
    endcase
  end

  // Sequencer and state update
  always_comb begin
    state_nxt       = state_r;
    ms_count_nxt    = ms_count_r;
    press_time_nxt  = press_time_r;
    pressed_nxt     = pressed_r;
    blink_mode_nxt  = blink_mode_r;
    blink_count_nxt = blink_count_r;
    led_nxt         = led_r;
    supply_nxt      = supply_r;
    pos_nxt         = pos_r;
    head_nxt        = head_r;
    trailer_nxt     = trailer_r;
    last_nxt        = last_r;
    whole_nxt       = whole_r;
    idx_nxt         = idx_r;

    out_valid_nxt    = out_valid_r && out_stall;
    out_tx_valid_nxt = out_tx_valid_r;
    out_tx_byte_nxt  = out_tx_byte_r;
    out_tx_last_nxt  = out_tx_last_r;
    out_led_nxt      = out_led_r;

    crc_cmd = '{start: 1'b0, clear: 1'b0, data: 8'h00};

    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          unique case (in_req_type)
            REQ_TICK: begin
              ms_count_nxt = ms_count_r + 32'd1;
              if (blink_mode_r) begin
                if (blink_inc >= blink_period_r) begin
                  blink_count_nxt = 8'd0;
                  led_nxt         = !led_r;
                end else begin
                  blink_count_nxt = blink_inc;
                end
              end else begin
                blink_count_nxt = 8'd0;
              end
            end
            REQ_BUTTON: begin
              if (in_pin_low && !pressed_r) begin
                pressed_nxt    = 1'b1;
                press_time_nxt = ms_count_r;
              end
            end
            REQ_SUPPLY: begin
              supply_nxt = in_supply_word;
            end
            REQ_RX: begin
              last_nxt  = in_rx_last;
              whole_nxt = (pos_r == POS_TRL_LO);
              state_nxt = ST_RX_WAIT;
              if (pos_r < POS_FULL) begin
                if (pos_r < POS_HEAD) begin
                  head_nxt[pos_r[1:0]] = in_rx_byte;
                end
                if (pos_r < POS_TRL_HI) begin
                  crc_cmd.start = 1'b1;
                  crc_cmd.data  = in_rx_byte;
                end else if (pos_r == POS_TRL_HI) begin
                  trailer_nxt[15:8] = in_rx_byte;
                end else begin
                  trailer_nxt[7:0] = in_rx_byte;
                end
                pos_nxt = pos_r + POS_W'(1);
              end else begin
                pos_nxt = POS_FULL;
              end
            end
            default: ;
          endcase
          // Status result for everything but a payload byte
          if (in_req_type != REQ_RX) begin
            out_valid_nxt    = 1'b1;
            out_tx_valid_nxt = 1'b0;
            out_tx_byte_nxt  = 8'h00;
            out_tx_last_nxt  = 1'b1;
            out_led_nxt      = led_nxt;
          end
        end
      end

      // Wait for the packet CRC, then close the byte or the packet
      ST_RX_WAIT: begin
        if (!crc_stat.busy) begin
          state_nxt = ST_IDLE;
          if (last_r) begin
            pos_nxt       = '0;
            crc_cmd.clear = 1'b1;
          end
          if (last_r && good && head_r[0] == own_address_r) begin
            if (head_r[1] == led_command_r) begin
              priority if (head_r[2] == led_on_r) begin
                led_nxt        = 1'b1;
                blink_mode_nxt = 1'b0;
              end else if (head_r[2] == led_off_r) begin
                led_nxt        = 1'b0;
                blink_mode_nxt = 1'b0;
              end else if (head_r[2] == led_blink_r) begin
                blink_mode_nxt = 1'b1;
              end
            end
            idx_nxt   = '0;
            state_nxt = ST_TX_LOAD;
          end else begin
            if (last_r && good && head_r[0] == reset_code_r) begin
              press_time_nxt = '0;
              ms_count_nxt   = '0;
              pressed_nxt    = 1'b0;
              blink_mode_nxt = 1'b0;
              led_nxt        = 1'b0;
            end
            out_valid_nxt    = 1'b1;
            out_tx_valid_nxt = 1'b0;
            out_tx_byte_nxt  = 8'h00;
            out_tx_last_nxt  = 1'b1;
            out_led_nxt      = led_nxt;
          end
        end
      end

      // Issue one reply byte and fold it into the reply CRC unless it is a CRC byte
      ST_TX_LOAD: begin
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          out_tx_valid_nxt = 1'b1;
          out_tx_byte_nxt  = reply_byte;
          out_tx_last_nxt  = (idx_r == IDX_CRC_LO);
          out_led_nxt      = led_r;
          if (idx_r < IDX_CRC_HI) begin
            crc_cmd.start = 1'b1;
            crc_cmd.data  = reply_byte;
            state_nxt     = ST_TX_WAIT;
          end else if (idx_r == IDX_CRC_LO) begin
            crc_cmd.clear = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end

      ST_TX_WAIT: begin
        if (!crc_stat.busy) begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = ST_TX_LOAD;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      ms_count_r     <= '0;
      press_time_r   <= '0;
      pressed_r      <= 1'b0;
      blink_mode_r   <= 1'b0;
      blink_count_r  <= '0;
      led_r          <= 1'b0;
      supply_r       <= '0;
      pos_r          <= '0;
      idx_r          <= '0;
      out_valid_r    <= 1'b0;
      own_address_r  <= 8'd1;
      reset_code_r   <= 8'd255;
      led_command_r  <= 8'd1;
      led_on_r       <= 8'd1;
      led_off_r      <= 8'd0;
      led_blink_r    <= 8'd2;
      not_pushed_r   <= 32'hFFFF_FFFF;
      blink_period_r <= 8'd100;
    end else begin
      state_r       <= state_nxt;
      ms_count_r    <= ms_count_nxt;
      press_time_r  <= press_time_nxt;
      pressed_r     <= pressed_nxt;
      blink_mode_r  <= blink_mode_nxt;
      blink_count_r <= blink_count_nxt;
      led_r         <= led_nxt;
      supply_r      <= supply_nxt;
      pos_r         <= pos_nxt;
      idx_r         <= idx_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_OWN_ADDRESS:  own_address_r  <= cfg_data[7:0];
          REG_RESET_CODE:   reset_code_r   <= cfg_data[7:0];
          REG_LED_COMMAND:  led_command_r  <= cfg_data[7:0];
          REG_LED_ON:       led_on_r       <= cfg_data[7:0];
          REG_LED_OFF:      led_off_r      <= cfg_data[7:0];
          REG_LED_BLINK:    led_blink_r    <= cfg_data[7:0];
          REG_NOT_PUSHED:   not_pushed_r   <= cfg_data;
          REG_BLINK_PERIOD: blink_period_r <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    head_r         <= head_nxt;
    trailer_r      <= trailer_nxt;
    last_r         <= last_nxt;
    whole_r        <= whole_nxt;
    out_tx_valid_r <= out_tx_valid_nxt;
    out_tx_byte_r  <= out_tx_byte_nxt;
    out_tx_last_r  <= out_tx_last_nxt;
    out_led_r      <= out_led_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_tx_valid = out_tx_valid_r;
  assign out_tx_byte  = out_tx_byte_r;
  assign out_tx_last  = out_tx_last_r;
  assign out_led_lit  = out_led_r;

`ifndef SYNTHESIS
  // CRC engine runs only while the sequencer waits on it
  a_crc_busy_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    crc_stat.busy |-> (state_r == ST_RX_WAIT || state_r == ST_TX_WAIT))
    else $error("CRC engine busy outside a wait state");

  // Receive position never passes the packet length
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_FULL)
    else $error("receive position out of range");

  // Between packets the running CRC is clear
  a_crc_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && pos_r == '0) |-> (crc_stat.crc == 16'h0000))
    else $error("running CRC not clear between packets");

  // Final reply byte returns the sequencer to idle
  a_reply_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TX_LOAD && out_free && idx_r == IDX_CRC_LO) |=>
      (state_r == ST_IDLE && out_tx_last_r && out_tx_valid_r))
    else $error("reply did not end on its last byte");
`endif

endmodule
